>>> hdl/ucl_pkg.sv
package ucl_pkg;

  // default sizes
  localparam int LINE_CHARS_DEF  = 80;
  localparam int FIELD_LIMIT_DEF = 5;
  localparam int NAME_CHARS_DEF  = 16;

  // character codes
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_BS     = 8'd8;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_LO_A   = 8'd97;
  localparam logic [7:0] CH_LO_F   = 8'd102;
  localparam logic [7:0] CH_LO_Z   = 8'd122;
  localparam logic [7:0] CH_UP_A   = 8'd65;
  localparam logic [7:0] CH_UP_Z   = 8'd90;
  localparam logic [7:0] CH_DIG_0  = 8'd48;
  localparam logic [7:0] CH_DIG_9  = 8'd57;
  localparam logic [7:0] CASE_GAP  = 8'd32;
  localparam logic [7:0] HEX_A_OFS = 8'd87;

  // command codes
  localparam logic [3:0] CMD_REBOOT  = 4'd0;
  localparam logic [3:0] CMD_PS      = 4'd1;
  localparam logic [3:0] CMD_IPCS    = 4'd2;
  localparam logic [3:0] CMD_KILL    = 4'd3;
  localparam logic [3:0] CMD_PKILL   = 4'd4;
  localparam logic [3:0] CMD_PI      = 4'd5;
  localparam logic [3:0] CMD_PREEMPT = 4'd6;
  localparam logic [3:0] CMD_SCHED   = 4'd7;
  localparam logic [3:0] CMD_PIDOF   = 4'd8;
  localparam logic [3:0] CMD_MEMINFO = 4'd9;
  localparam logic [3:0] CMD_RESTART = 4'd10;
  localparam int         CMD_WORDS   = 10;

  // argument words, indexed after the command words
  localparam logic [3:0] WORD_ON   = 4'd10;
  localparam logic [3:0] WORD_PRIO = 4'd11;

  // result kinds
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_NAME   = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic in_take;
    logic scan_rd;
    logic scan_step;
    logic hdr_load;
    logic name_rd;
    logic name_load;
  } ucl_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic line_end;
    logic scan_end;
    logic out_free;
    logic emit_zero;
    logic name_last;
  } ucl_sts_t;

  // byte j of a word, zero past its end
  function automatic logic [7:0] word_byte(input logic [3:0] k, input logic [2:0] j);
    logic [63:0] w;
    w = 64'h0;
    case (k)
      CMD_REBOOT:  w = {"reboot", 16'h0};
      CMD_PS:      w = {"ps", 48'h0};
      CMD_IPCS:    w = {"ipcs", 32'h0};
      CMD_KILL:    w = {"kill", 32'h0};
      CMD_PKILL:   w = {"pkill", 24'h0};
      CMD_PI:      w = {"pi", 48'h0};
      CMD_PREEMPT: w = {"preempt", 8'h0};
      CMD_SCHED:   w = {"sched", 24'h0};
      CMD_PIDOF:   w = {"pidof", 24'h0};
      CMD_MEMINFO: w = {"meminfo", 8'h0};
      WORD_ON:     w = {"on", 48'h0};
      WORD_PRIO:   w = {"prio", 32'h0};
      default:     w = 64'h0;
    endcase
    return w[63 - 8*j -: 8];
  endfunction

  // minimum argument count of each command word
  function automatic logic min_args(input logic [3:0] k);
    logic r;
    r = 1'b0;
    case (k)
      CMD_KILL, CMD_PKILL, CMD_PI, CMD_PREEMPT, CMD_SCHED, CMD_PIDOF: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    return (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_GAP : c;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_DIG_0 && c <= CH_DIG_9);
  endfunction

endpackage

>>> hdl/ucl_ram.sv
module ucl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 80
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/ucl_ctrl.sv
module ucl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ucl_pkg::ucl_sts_t sts,
  output ucl_pkg::ucl_ctl_t ctl
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SRD  = 3'd1;
  localparam logic [2:0] ST_SPR  = 3'd2;
  localparam logic [2:0] ST_HDR  = 3'd3;
  localparam logic [2:0] ST_NRD  = 3'd4;
  localparam logic [2:0] ST_NPR  = 3'd5;

  logic [2:0] state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      ST_IDLE: begin
        ctl.in_take = in_valid;
        if (in_valid && sts.line_end) state_nxt = ST_SRD;
      end
      ST_SRD: begin
        ctl.scan_rd = !sts.scan_end;
        state_nxt   = ST_SPR;
      end
      ST_SPR: begin
        ctl.scan_step = 1'b1;
        state_nxt     = sts.scan_end ? ST_HDR : ST_SRD;
      end
      ST_HDR: begin
        if (sts.out_free) begin
          ctl.hdr_load = 1'b1;
          state_nxt    = sts.emit_zero ? ST_IDLE : ST_NRD;
        end
      end
      ST_NRD: begin
        ctl.name_rd = 1'b1;
        state_nxt   = ST_NPR;
      end
      ST_NPR: begin
        if (sts.out_free) begin
          ctl.name_load = 1'b1;
          state_nxt     = sts.name_last ? ST_IDLE : ST_NRD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  // a finished walk always leads to the header
  a_scan_to_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.scan_step && sts.scan_end |=> state_r == ST_HDR)
    else $error("walk end did not reach header");

  // only one result is loaded per cycle
  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.hdr_load && ctl.name_load))
    else $error("two loads at once");

  // a line end beat starts the walk
  a_line_start: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.in_take && sts.line_end |=> state_r == ST_SRD)
    else $error("line end did not start walk");

endmodule

>>> hdl/ucl_dp.sv
module ucl_dp #(
  parameter int LINE_CHARS  = ucl_pkg::LINE_CHARS_DEF,
  parameter int FIELD_LIMIT = ucl_pkg::FIELD_LIMIT_DEF,
  parameter int NAME_CHARS  = ucl_pkg::NAME_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_rx_byte,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              out_result_kind,
  output logic [3:0]        out_command,
  output logic [2:0]        out_field_count,
  output logic              out_switch_on,
  output logic [31:0]       out_pid_value,
  output logic [7:0]        out_name_char,
  output logic              out_name_cut,
  output logic              out_last,
  input  ucl_pkg::ucl_ctl_t ctl,
  output ucl_pkg::ucl_sts_t sts
);

  localparam int IW = $clog2(LINE_CHARS + 1);
  localparam int AW = $clog2(LINE_CHARS);
  localparam int FW = $clog2(FIELD_LIMIT + 1);
  localparam int NW = $clog2(NAME_CHARS + 2);
  localparam int PW = IW + NW;

  // line editing
  logic [IW-1:0] len_r, len_nxt;
  logic          full, line_end, is_print, is_erase, wr_en;

  // line end walk
  logic [IW-1:0]            n_r, idx_r, fpos0_r, fpos1_r, stop_r;
  logic [FW-1:0]            fcnt_r, cur_r;
  logic                     in_field_r;
  logic [2:0]               off_r;
  logic [ucl_pkg::CMD_WORDS-1:0] mvec_r;
  logic                     on_r, prio_r, hex_r;
  logic [31:0]              pid_r;
  logic [NW-1:0]            len0_r, len1_r, j_r;

  // output register
  logic        ovalid_r;
  logic        okind_r, osw_r, ocut_r, olast_r;
  logic [3:0]  ocmd_r;
  logic [2:0]  ofc_r;
  logic [31:0] opid_r;
  logic [7:0]  ochar_r;

  logic [7:0]    rd_data, folded, eff, name_ch;
  logic          stopped, active, at_end;
  logic [FW-1:0] fsel;
  logic [2:0]    offs;
  logic [3:0]    hex_d;
  logic          hex_ok;
  logic [3:0]    cmd;
  logic [2:0]    fc;
  logic          sw;
  logic [31:0]   pid;
  logic [NW-1:0] name_len, emit;
  logic          cut;
  logic [IW-1:0] name_pos;
  logic [PW-1:0] name_addr;
  logic [AW-1:0] rd_addr;

  // input beat decode
  assign full     = (len_r == IW'(LINE_CHARS));
  assign line_end = (in_rx_byte == ucl_pkg::CH_CR) || full;
  assign is_print = (in_rx_byte >= ucl_pkg::CH_SPACE) && (in_rx_byte < ucl_pkg::CH_DEL);
  assign is_erase = (in_rx_byte == ucl_pkg::CH_BS) || (in_rx_byte == ucl_pkg::CH_DEL);
  assign wr_en    = ctl.in_take && !line_end && is_print;

  always_comb begin
    len_nxt = len_r;
    if (ctl.in_take) begin
      if (line_end) len_nxt = '0;
      else if (is_print) len_nxt = len_r + 1'b1;
      else if (is_erase && len_r != '0) len_nxt = len_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  // line store
  assign name_addr = PW'(name_pos) + PW'(j_r);
  assign rd_addr   = ctl.name_rd ? AW'(name_addr) : AW'(idx_r);

  ucl_ram #(.WIDTH(8), .DEPTH(LINE_CHARS)) u_line (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(len_r)),
    .wr_data (in_rx_byte),
    .rd_en   (ctl.scan_rd || ctl.name_rd),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // effective character at the walk position
  assign at_end  = (idx_r == n_r);
  assign stopped = (fcnt_r >= FW'(FIELD_LIMIT));
  assign folded  = ucl_pkg::fold(rd_data);
  always_comb begin
    if (at_end) eff = 8'h0;
    else if (stopped) eff = rd_data;
    else eff = ucl_pkg::is_alnum(folded) ? folded : 8'h0;
  end
  assign active = in_field_r || (eff != 8'h0);
  assign fsel   = in_field_r ? cur_r : fcnt_r;
  assign offs   = in_field_r ? off_r : 3'd0;

  // hex digit
  always_comb begin
    hex_ok = 1'b1;
    hex_d  = 4'h0;
    if (eff >= ucl_pkg::CH_DIG_0 && eff <= ucl_pkg::CH_DIG_9) begin
      hex_d = 4'(eff - ucl_pkg::CH_DIG_0);
    end else if (eff >= ucl_pkg::CH_LO_A && eff <= ucl_pkg::CH_LO_F) begin
      hex_d = 4'(eff - ucl_pkg::HEX_A_OFS);
    end else begin
      hex_ok = 1'b0;
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (ctl.in_take && line_end) begin
      n_r        <= len_r;
      idx_r      <= '0;
      fcnt_r     <= '0;
      cur_r      <= '0;
      in_field_r <= 1'b0;
      off_r      <= '0;
      mvec_r     <= '1;
      on_r       <= 1'b1;
      prio_r     <= 1'b1;
      hex_r      <= 1'b1;
      pid_r      <= '0;
      len0_r     <= '0;
      len1_r     <= '0;
      fpos0_r    <= '0;
      fpos1_r    <= '0;
      stop_r     <= IW'(LINE_CHARS);
      j_r        <= '0;
    end else if (ctl.scan_step) begin
      if (!at_end) idx_r <= idx_r + 1'b1;
      if (active && fsel == FW'(0)) begin
        for (int k = 0; k < ucl_pkg::CMD_WORDS; k++) begin
          if (eff != ucl_pkg::word_byte(4'(k), offs)) mvec_r[k] <= 1'b0;
        end
        if (eff != 8'h0 && len0_r < NW'(NAME_CHARS + 1)) len0_r <= len0_r + 1'b1;
      end
      if (active && fsel == FW'(1)) begin
        if (eff != ucl_pkg::word_byte(ucl_pkg::WORD_ON, offs)) on_r <= 1'b0;
        if (eff != ucl_pkg::word_byte(ucl_pkg::WORD_PRIO, offs)) prio_r <= 1'b0;
        if (hex_r && hex_ok) pid_r <= {pid_r[27:0], hex_d};
        else hex_r <= 1'b0;
        if (eff != 8'h0 && len1_r < NW'(NAME_CHARS + 1)) len1_r <= len1_r + 1'b1;
      end
      // field start, continuation and end
      if (!in_field_r && eff != 8'h0) begin
        cur_r      <= fcnt_r;
        fcnt_r     <= fcnt_r + 1'b1;
        in_field_r <= 1'b1;
        off_r      <= 3'd1;
        if (fcnt_r == FW'(0)) fpos0_r <= idx_r;
        if (fcnt_r == FW'(1)) fpos1_r <= idx_r;
        if (fcnt_r == FW'(FIELD_LIMIT - 1)) stop_r <= idx_r + 1'b1;
      end else if (in_field_r) begin
        if (eff == 8'h0) in_field_r <= 1'b0;
        else if (off_r != 3'd7) off_r <= off_r + 1'b1;
      end
    end else if (ctl.name_load) begin
      j_r <= j_r + 1'b1;
    end
  end

  // command decode, first match wins
  always_comb begin
    cmd = ucl_pkg::CMD_RESTART;
    for (int k = ucl_pkg::CMD_WORDS - 1; k >= 0; k--) begin
      if (mvec_r[k] && fcnt_r > FW'(ucl_pkg::min_args(4'(k)))) cmd = 4'(k);
    end
  end

  assign fc = (fcnt_r > FW'(7)) ? 3'd7 : 3'(fcnt_r);

  always_comb begin
    sw  = 1'b0;
    pid = '0;
    case (cmd)
      ucl_pkg::CMD_KILL:    pid = pid_r;
      ucl_pkg::CMD_PI:      sw  = on_r;
      ucl_pkg::CMD_PREEMPT: sw  = on_r;
      ucl_pkg::CMD_SCHED:   sw  = prio_r;
      default:              sw  = 1'b0;
    endcase
  end

  // name argument
  always_comb begin
    name_pos = fpos0_r;
    name_len = '0;
    if (cmd == ucl_pkg::CMD_PKILL || cmd == ucl_pkg::CMD_PIDOF) begin
      name_pos = fpos1_r;
      name_len = len1_r;
    end else if (cmd == ucl_pkg::CMD_RESTART && fcnt_r != '0) begin
      name_len = len0_r;
    end
  end
  assign cut     = (name_len > NW'(NAME_CHARS));
  assign emit    = cut ? NW'(NAME_CHARS) : name_len;
  assign name_ch = (name_addr >= PW'(stop_r)) ? rd_data : folded;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (ctl.hdr_load || ctl.name_load) begin
      ovalid_r <= 1'b1;
    end else if (!out_stall) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.hdr_load) begin
      okind_r <= ucl_pkg::KIND_HEADER;
      ocmd_r  <= cmd;
      ofc_r   <= fc;
      osw_r   <= sw;
      opid_r  <= pid;
      ochar_r <= 8'h0;
      ocut_r  <= cut;
      olast_r <= (emit == '0);
    end else if (ctl.name_load) begin
      okind_r <= ucl_pkg::KIND_NAME;
      ocmd_r  <= cmd;
      ofc_r   <= fc;
      osw_r   <= 1'b0;
      opid_r  <= '0;
      ochar_r <= name_ch;
      ocut_r  <= cut;
      olast_r <= (NW'(j_r + 1'b1) == emit);
    end
  end

  assign out_valid       = ovalid_r;
  assign out_result_kind = okind_r;
  assign out_command     = ocmd_r;
  assign out_field_count = ofc_r;
  assign out_switch_on   = osw_r;
  assign out_pid_value   = opid_r;
  assign out_name_char   = ochar_r;
  assign out_name_cut    = ocut_r;
  assign out_last        = olast_r;

  // status
  assign sts.line_end  = line_end;
  assign sts.scan_end  = at_end;
  assign sts.out_free  = !ovalid_r || !out_stall;
  assign sts.emit_zero = (emit == '0);
  assign sts.name_last = (NW'(j_r + 1'b1) == emit);

  // line length stays within the store
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= IW'(LINE_CHARS))
    else $error("line length beyond store");

  // a line end beat empties the line
  a_len_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.in_take && line_end |=> len_r == '0)
    else $error("line not cleared at line end");

  // field count never passes the limit
  a_fcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.scan_step |-> fcnt_r <= FW'(FIELD_LIMIT))
    else $error("field count beyond limit");

endmodule

>>> hdl/uart_command_line_parser.sv
// serial command line parser
// input channel: one received byte per beat (in_valid, in_stall, in_rx_byte).
// printable bytes go into the line store, backspace and delete remove the
// last byte, other bytes are dropped; these beats give no result.
// enter, or any byte when the line is full, ends the line. the block then
// stalls its input and walks the stored line one character at a time
// (one line store read, one step of the field scanner), then loads the
// header beat into the output register once that register is free.
// for pkill, pidof and task restart up to NAME_CHARS name character beats
// follow the header, each read from the line store and then loaded.
// out_last marks the final beat of a line.
// results sit in an output register; while out_stall is high the beat holds
// and the block waits, but it accepts new bytes once the last result of a
// line is loaded.
// reset empties the line and drops any pending result; the line store
// contents are not cleared.
module uart_command_line_parser #(
  parameter int LINE_CHARS  = ucl_pkg::LINE_CHARS_DEF,
  parameter int FIELD_LIMIT = ucl_pkg::FIELD_LIMIT_DEF,
  parameter int NAME_CHARS  = ucl_pkg::NAME_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [3:0]  out_command,
  output logic [2:0]  out_field_count,
  output logic        out_switch_on,
  output logic [31:0] out_pid_value,
  output logic [7:0]  out_name_char,
  output logic        out_name_cut,
  output logic        out_last
);

  ucl_pkg::ucl_ctl_t ctl;
  ucl_pkg::ucl_sts_t sts;

  // sequencer
  ucl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  // line store, scanner and output register
  ucl_dp #(
    .LINE_CHARS  (LINE_CHARS),
    .FIELD_LIMIT (FIELD_LIMIT),
    .NAME_CHARS  (NAME_CHARS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_rx_byte      (in_rx_byte),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_result_kind (out_result_kind),
    .out_command     (out_command),
    .out_field_count (out_field_count),
    .out_switch_on   (out_switch_on),
    .out_pid_value   (out_pid_value),
    .out_name_char   (out_name_char),
    .out_name_cut    (out_name_cut),
    .out_last        (out_last),
    .ctl             (ctl),
    .sts             (sts)
  );

endmodule

>>> dv/uart_command_line_parser_tb.sv
module uart_command_line_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_MAX  = ucl_pkg::LINE_CHARS_DEF;
  localparam int FIELD_MAX = ucl_pkg::FIELD_LIMIT_DEF;
  localparam int NAME_MAX  = ucl_pkg::NAME_CHARS_DEF;
  localparam int ITEM_GOAL = 360;

  typedef struct packed {
    logic        kind;
    logic [3:0]  command;
    logic [2:0]  field_count;
    logic        switch_on;
    logic [31:0] pid_value;
    logic [7:0]  name_char;
    logic        name_cut;
    logic        last;
  } parse_beat_t;

  typedef struct {
    string      text;
    int         reps;
    logic [7:0] ender;
    bit         typed;
    logic [3:0] command;
    logic [2:0] field_count;
  } line_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_result_kind;
  logic [3:0]  out_command;
  logic [2:0]  out_field_count;
  logic        out_switch_on;
  logic [31:0] out_pid_value;
  logic [7:0]  out_name_char;
  logic        out_name_cut;
  logic        out_last;

  // line predictor state
  logic [7:0]  line_buf [LINE_MAX];
  int          line_len = 0;
  logic [7:0]  work_buf [LINE_MAX+1];
  int          field_pos [FIELD_MAX];
  int          field_num;
  parse_beat_t last_header;
  parse_beat_t expected_beats [$];

  int errors = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  string cmd_words [ucl_pkg::CMD_WORDS] = '{"reboot", "ps", "ipcs", "kill", "pkill",
                                            "pi", "preempt", "sched", "pidof", "meminfo"};
  int    cmd_min   [ucl_pkg::CMD_WORDS] = '{0, 0, 0, 1, 1, 1, 1, 1, 1, 0};

  uart_command_line_parser u_top (.*);

  always #1 clk = ~clk;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  function automatic bit word_at(int p, string w);
    logic [7:0] a;
    logic [7:0] b;
    for (int i = 0; i < LINE_MAX + 2; i++) begin
      a = (p + i <= LINE_MAX) ? work_buf[p + i] : 8'h00;
      b = (i < w.len()) ? w[i] : 8'h00;
      if (a != b) return 1'b0;
      if (a == 8'h00) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [31:0] hex_value(int p);
    logic [31:0] v;
    logic [7:0]  ch;
    v = '0;
    while (p <= LINE_MAX) begin
      ch = work_buf[p];
      if (ch >= ucl_pkg::CH_DIG_0 && ch <= ucl_pkg::CH_DIG_9)
        v = {v[27:0], 4'(ch - ucl_pkg::CH_DIG_0)};
      else if (ch >= ucl_pkg::CH_LO_A && ch <= ucl_pkg::CH_LO_F)
        v = {v[27:0], 4'(ch - ucl_pkg::HEX_A_OFS)};
      else break;
      p++;
    end
    return v;
  endfunction

  // fold one accepted byte into the line; at line end queue the beats it gives
  function automatic void parse_byte(logic [7:0] b);
    int          n;
    int          name_at;
    int          name_len;
    int          emit;
    bit          in_run;
    bit          has_name;
    logic [7:0]  ch;
    logic [3:0]  cmd;
    parse_beat_t beat;
    if (b != ucl_pkg::CH_CR && line_len < LINE_MAX) begin
      if ((b == ucl_pkg::CH_BS || b == ucl_pkg::CH_DEL) && line_len > 0) begin
        line_len--;
      end
      if (b >= ucl_pkg::CH_SPACE && b < ucl_pkg::CH_DEL) begin
        line_buf[line_len] = b;
        line_len++;
      end
      return;
    end
    n = line_len;
    for (int i = 0; i < n; i++) work_buf[i] = line_buf[i];
    work_buf[n] = 8'h00;
    line_len = 0;
    // split into alphanumeric runs until the field limit is reached
    field_num = 0;
    in_run = 1'b0;
    for (int i = 0; i < FIELD_MAX; i++) field_pos[i] = 0;
    for (int i = 0; i < n; i++) begin
      if (field_num >= FIELD_MAX) break;
      ch = work_buf[i];
      if (ch >= ucl_pkg::CH_UP_A && ch <= ucl_pkg::CH_UP_Z) begin
        ch = ch + ucl_pkg::CASE_GAP;
        work_buf[i] = ch;
      end
      if ((ch >= ucl_pkg::CH_LO_A && ch <= ucl_pkg::CH_LO_Z) ||
          (ch >= ucl_pkg::CH_DIG_0 && ch <= ucl_pkg::CH_DIG_9)) begin
        if (!in_run) begin
          field_pos[field_num] = i;
          field_num++;
          in_run = 1'b1;
        end
      end else begin
        in_run = 1'b0;
        work_buf[i] = 8'h00;
      end
    end
    // command word lookup
    cmd = ucl_pkg::CMD_RESTART;
    for (int k = 0; k < ucl_pkg::CMD_WORDS; k++)
      if (field_num >= cmd_min[k] + 1 && word_at(field_pos[0], cmd_words[k])) begin
        cmd = 4'(k);
        break;
      end
    beat = '0;
    beat.kind = ucl_pkg::KIND_HEADER;
    beat.command = cmd;
    beat.field_count = (field_num > 7) ? 3'd7 : 3'(field_num);
    if (cmd == ucl_pkg::CMD_KILL) beat.pid_value = hex_value(field_pos[1]);
    else if (cmd == ucl_pkg::CMD_PI || cmd == ucl_pkg::CMD_PREEMPT)
      beat.switch_on = word_at(field_pos[1], "on");
    else if (cmd == ucl_pkg::CMD_SCHED) beat.switch_on = word_at(field_pos[1], "prio");
    has_name = 1'b0;
    name_at = 0;
    if (cmd == ucl_pkg::CMD_PKILL || cmd == ucl_pkg::CMD_PIDOF) begin
      has_name = 1'b1;
      name_at = field_pos[1];
    end else if (cmd == ucl_pkg::CMD_RESTART && field_num > 0) begin
      has_name = 1'b1;
      name_at = field_pos[0];
    end
    name_len = 0;
    if (has_name)
      while (name_at + name_len <= LINE_MAX && work_buf[name_at + name_len] != 8'h00)
        name_len++;
    emit = (name_len > NAME_MAX) ? NAME_MAX : name_len;
    beat.name_cut = (name_len > NAME_MAX);
    beat.last = (emit == 0);
    last_header = beat;
    expected_beats.push_back(beat);
    // name characters follow the header
    for (int r = 0; r < emit; r++) begin
      beat.kind = ucl_pkg::KIND_NAME;
      beat.switch_on = 1'b0;
      beat.pid_value = '0;
      beat.name_char = work_buf[name_at + r];
      beat.last = (r + 1 == emit);
      expected_beats.push_back(beat);
    end
  endfunction

  // one byte beat, with idle cycles ahead of it; entered and left at a falling edge
  task automatic send_byte(logic [7:0] b);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_rx_byte = b;
    do begin
      @(posedge clk);
      taken = !in_stall;
      if (taken) begin
        items_sent++;
        parse_byte(b);
      end
      @(negedge clk);
    end while (!taken);
    in_valid = 1'b0;
  endtask

  task automatic send_text(string s, int reps, logic [7:0] ender);
    for (int r = 0; r < reps; r++)
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(ender);
  endtask

  // random line: mostly command shaped, the rest noise or overlong
  task automatic send_random_line();
    string       s;
    string       w;
    string       seps;
    string       hex_set;
    string       alnum_set;
    int          sel;
    int          nargs;
    int          len;
    logic [7:0]  c;
    s = "";
    seps = " ,;-/.\t_";
    hex_set = "0123456789abcdefgx";
    alnum_set = "abcdefghijklmnopqrstuvwxyz0123456789";
    sel = $urandom_range(99);
    if (sel < 72) begin
      w = ($urandom_range(9) == 0) ? "task1" : cmd_words[$urandom_range(ucl_pkg::CMD_WORDS-1)];
      nargs = $urandom_range(3);
      for (int a = 0; a < nargs; a++) begin
        w = {w, string'(seps[$urandom_range(seps.len()-1)])};
        case ($urandom_range(3))
          0: begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) w = {w, string'(hex_set[$urandom_range(17)])};
          end
          1: begin
            if ($urandom_range(1)) w = {w, "on"};
            else w = {w, "off"};
          end
          2: begin
            if ($urandom_range(1)) w = {w, "prio"};
            else w = {w, "rr"};
          end
          default: begin
            len = $urandom_range(1, 22);
            for (int i = 0; i < len; i++)
              w = {w, string'(alnum_set[$urandom_range(35)])};
          end
        endcase
      end
      // random case, leading blanks and the odd corrected typo
      for (int i = 0; i < w.len(); i++) begin
        c = w[i];
        if (c >= ucl_pkg::CH_LO_A && c <= ucl_pkg::CH_LO_Z && $urandom_range(3) == 0)
          c = c - ucl_pkg::CASE_GAP;
        if ($urandom_range(19) == 0)
          s = {s, "Q", string'(($urandom_range(1) ? ucl_pkg::CH_BS : ucl_pkg::CH_DEL))};
        s = {s, string'(c)};
      end
      if ($urandom_range(4) == 0) s = {"  ", s};
    end else if (sel < 92) begin
      len = $urandom_range(30);
      for (int i = 0; i < len; i++) s = {s, string'(8'($urandom_range(255)))};
    end else begin
      len = $urandom_range(60, 84);
      for (int i = 0; i < len; i++) s = {s, string'(8'($urandom_range(32, 126)))};
    end
    foreach (s[i]) send_byte(s[i]);
    send_byte(($urandom_range(9) == 0) ? 8'($urandom_range(255)) : ucl_pkg::CH_CR);
  endtask

  // directed lines, header typed where it is obvious
  line_row_t rows [] = '{
    '{"", 1, ucl_pkg::CH_CR, 1, ucl_pkg::CMD_RESTART, 3'd0},
    '{"\010\177", 1, ucl_pkg::CH_CR, 1, ucl_pkg::CMD_RESTART, 3'd0},
    '{"\001\377\200 \037", 1, ucl_pkg::CH_CR, 1, ucl_pkg::CMD_RESTART, 3'd0},
    '{"reboot", 1, ucl_pkg::CH_CR, 1, ucl_pkg::CMD_REBOOT, 3'd1},
    '{"PS", 1, ucl_pkg::CH_CR, 1, ucl_pkg::CMD_PS, 3'd1},
    '{"ipcs extra", 1, ucl_pkg::CH_CR, 1, ucl_pkg::CMD_IPCS, 3'd2},
    '{"kill", 1, ucl_pkg::CH_CR, 1, ucl_pkg::CMD_RESTART, 3'd1},
    '{"kill 1A2b", 1, ucl_pkg::CH_CR, 1, ucl_pkg::CMD_KILL, 3'd2},
    '{"kill ffffffffff9", 1, ucl_pkg::CH_CR, 0, ucl_pkg::CMD_KILL, 3'd2},
    '{"kill 0", 1, ucl_pkg::CH_CR, 0, ucl_pkg::CMD_KILL, 3'd2},
    '{"kill 12g4", 1, ucl_pkg::CH_CR, 0, ucl_pkg::CMD_KILL, 3'd2},
    '{"pkill Shell", 1, ucl_pkg::CH_CR, 1, ucl_pkg::CMD_PKILL, 3'd2},
    '{"pi on", 1, ucl_pkg::CH_CR, 1, ucl_pkg::CMD_PI, 3'd2},
    '{"preempt off", 1, ucl_pkg::CH_CR, 1, ucl_pkg::CMD_PREEMPT, 3'd2},
    '{"sched PRIO", 1, ucl_pkg::CH_CR, 1, ucl_pkg::CMD_SCHED, 3'd2},
    '{"sched rr", 1, ucl_pkg::CH_CR, 1, ucl_pkg::CMD_SCHED, 3'd2},
    '{"pidof idle", 1, ucl_pkg::CH_CR, 1, ucl_pkg::CMD_PIDOF, 3'd2},
    '{"meminfo", 1, ucl_pkg::CH_CR, 1, ucl_pkg::CMD_MEMINFO, 3'd1},
    '{"pidof abcdefghijklmnopqrstuvwxyz", 1, ucl_pkg::CH_CR, 1, ucl_pkg::CMD_PIDOF, 3'd2},
    '{"a b c d e f-g h", 1, ucl_pkg::CH_CR, 1, ucl_pkg::CMD_RESTART, 3'd5},
    '{"rebootx\010", 1, ucl_pkg::CH_CR, 1, ucl_pkg::CMD_REBOOT, 3'd1},
    '{"Ab1 ", 20, 8'hFF, 1, ucl_pkg::CMD_RESTART, 3'd5},
    '{"x", 20, ucl_pkg::CH_CR, 1, ucl_pkg::CMD_RESTART, 3'd1},
    '{"pkillname", 1, ucl_pkg::CH_CR, 1, ucl_pkg::CMD_RESTART, 3'd1}
  };

  // result side: random stall, checked at the rising edge
  always @(negedge clk)
    out_stall = ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    parse_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        report("unexpected beat", out_command, 0);
      end else begin
        want = expected_beats.pop_front();
        if (out_result_kind != want.kind) report("result_kind", out_result_kind, want.kind);
        if (out_command != want.command) report("command", out_command, want.command);
        if (out_field_count != want.field_count)
          report("field_count", out_field_count, want.field_count);
        if (out_switch_on != want.switch_on) report("switch_on", out_switch_on, want.switch_on);
        if (out_pid_value != want.pid_value) report("pid_value", out_pid_value, want.pid_value);
        if (out_name_char != want.name_char) report("name_char", out_name_char, want.name_char);
        if (out_name_cut != want.name_cut) report("name_cut", out_name_cut, want.name_cut);
        if (out_last != want.last) report("last", out_last, want.last);
      end
    end
  end

  initial begin
    int lines;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    // directed lines, unhurried
    foreach (rows[i]) begin
      send_text(rows[i].text, rows[i].reps, rows[i].ender);
      if (rows[i].typed) begin
        if (last_header.command != rows[i].command)
          report("directed command", last_header.command, rows[i].command);
        if (last_header.field_count != rows[i].field_count)
          report("directed field_count", last_header.field_count, rows[i].field_count);
      end
    end
    // random lines, cycling through the idling phases
    lines = 0;
    while (items_sent < ITEM_GOAL || lines < 4) begin
      case (lines % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      send_random_line();
      lines++;
    end
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0)
      $display("uart_command_line_parser verification clean");
    else
      $display("uart_command_line_parser verification failed");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("uart_command_line_parser verification failed");
    $finish;
  end

endmodule
